FILE: src/ard_pkg.sv
// ----------------------------------------------------------------------------
// ard_pkg: shared definitions for the AT response +IPD deframer
// Event codes, configuration register indexes, protocol characters and the
// keyword table that the line matcher compares against.
// ----------------------------------------------------------------------------
package ard_pkg;

    // Default width of the chunk and packet length counters.
    localparam int LENGTH_BITS_DEF = 16;

    // Configuration port layout.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_SUPPRESS_CLOSED    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_SUPPRESS_WIFI_DROP = 1'b1;

    // Result event codes.
    typedef enum logic [3:0] {
        EV_NONE         = 4'd0,
        EV_OK           = 4'd1,
        EV_FAIL         = 4'd2,
        EV_ERROR        = 4'd3,
        EV_SEND_OK      = 4'd4,
        EV_SEND_FAIL    = 4'd5,
        EV_CLOSED       = 4'd6,
        EV_WIFI_DROP    = 4'd7,
        EV_PAYLOAD      = 4'd8,
        EV_PAYLOAD_LAST = 4'd9,
        EV_FRAME_ERROR  = 4'd10,
        EV_CHUNK_DONE   = 4'd11
    } t_event;

    // Protocol characters.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Line keyword table. Each entry is right aligned: the last character of
    // a keyword sits in the lowest byte.
    localparam int KW_COUNT   = 7;
    localparam int KW_MAX_LEN = 17;
    localparam int POS_BITS   = 5;

    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        (8*KW_MAX_LEN)'("OK\r\n"),
        (8*KW_MAX_LEN)'("FAIL\r\n"),
        (8*KW_MAX_LEN)'("ERROR\r\n"),
        (8*KW_MAX_LEN)'("SEND OK\r\n"),
        (8*KW_MAX_LEN)'("SEND FAIL\r\n"),
        (8*KW_MAX_LEN)'("CLOSED\r\n"),
        (8*KW_MAX_LEN)'("WIFI DISCONNECT\r\n")
    };

    localparam logic [POS_BITS-1:0] KW_LEN [KW_COUNT] = '{
        5'd4, 5'd6, 5'd7, 5'd9, 5'd11, 5'd8, 5'd17
    };

    localparam t_event KW_EVENT [KW_COUNT] = '{
        EV_OK, EV_FAIL, EV_ERROR, EV_SEND_OK, EV_SEND_FAIL, EV_CLOSED, EV_WIFI_DROP
    };

    // True when byte b equals character pos of keyword k.
    function automatic logic kw_hit(input logic [2:0] k,
                                    input logic [POS_BITS-1:0] pos,
                                    input logic [7:0] b);
        int idx;
        idx = int'(KW_LEN[k]) - 1 - int'(pos);
        if (pos >= KW_LEN[k]) begin
            return 1'b0;
        end
        return KW_TEXT[k][8*idx +: 8] == b;
    endfunction

    // True for an ASCII decimal digit.
    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

FILE: src/ard_in_if.sv
// ----------------------------------------------------------------------------
// ard_in_if: received byte channel
// Valid/ready channel that carries one byte from the modem serial link.
// ----------------------------------------------------------------------------
interface ard_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/ard_out_if.sv
// ----------------------------------------------------------------------------
// ard_out_if: result channel
// Valid/ready channel that carries one event code and its payload byte.
// ----------------------------------------------------------------------------
interface ard_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] data_byte;

    modport source (output valid, output event_res, output data_byte, input ready);
    modport sink   (input valid, input event_res, input data_byte, output ready);
endinterface

FILE: src/at_response_ipd_deframer_top.sv
// ----------------------------------------------------------------------------
// at_response_ipd_deframer_top: AT response parser with +IPD deframing
// Parses the byte stream of an AT command modem: reports status lines and
// unpacks the payload of framed packets carried in +IPD data chunks.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one received byte per item. o_out returns exactly one item
//   per input byte: an event code and, for payload events, the payload byte.
//   The configuration port writes the two suppress bits; write them only
//   while no byte is in flight.
// Timing:
//   A byte is captured in an input register when it is accepted and is
//   parsed from there. Its result is written into the output register when
//   that register is free or being emptied, and the receiver takes it from
//   there. The parse is one pass of shallow logic over the line state, so
//   one byte per cycle is sustained while the receiver takes every result.
// Stalls:
//   When the receiver holds o_out.ready low, the result waits in the output
//   register and one more byte can still be accepted into the input
//   register; after that i_in.ready drops until the result is taken.
// Reset:
//   A synchronous reset returns the parser to the start of a line, clears
//   the inner framer, the lengths and the suppress bits, and empties both
//   registers. No item is accepted while reset is held.
// ----------------------------------------------------------------------------
module at_response_ipd_deframer_top #(
    parameter int LENGTH_BITS = ard_pkg::LENGTH_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [ard_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ard_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    ard_in_if.sink                             i_in,
    ard_out_if.source                          o_out
);

    localparam int LB = LENGTH_BITS;

    typedef enum logic [3:0] {
        LS_NEW_LINE   = 4'd0,
        LS_NORMAL     = 4'd1,
        LS_PLUS       = 4'd2,
        LS_PLUS_I     = 4'd3,
        LS_PLUS_IP    = 4'd4,
        LS_PLUS_IPD   = 4'd5,
        LS_CR         = 4'd6,
        LS_CHUNK_LEN  = 4'd7,
        LS_CHUNK_DATA = 4'd8
    } t_line_state;

    typedef enum logic [1:0] {
        FS_EXPECT_S = 2'd0,
        FS_LENGTH   = 2'd1,
        FS_DATA     = 2'd2
    } t_frame_state;

    // Decimal accumulate v*10 + digit, saturating at the counter maximum.
    function automatic logic [LB-1:0] acc_dec(input logic [LB-1:0] v,
                                              input logic [7:0] b);
        logic [LB+3:0] s;
        s = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{LB{1'b0}}, b[3:0]};
        if (|s[LB+3:LB]) begin
            return '1;
        end
        return s[LB-1:0];
    endfunction

    // Saturating increment.
    function automatic logic [LB-1:0] sat_inc(input logic [LB-1:0] v);
        return (v != '1) ? v + LB'(1) : v;
    endfunction

    // Registers.
    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_out_valid;
    ard_pkg::t_event              r_out_event;
    logic [7:0]                   r_out_data;
    logic                         r_sup_closed;
    logic                         r_sup_wifi;
    t_line_state                  r_line_state;
    logic [LB-1:0]                r_chunk_len;
    logic [LB-1:0]                r_chunk_cnt;
    t_frame_state                 r_frame_state;
    logic [LB-1:0]                r_pkt_len;
    logic [LB-1:0]                r_pkt_cnt;
    logic [ard_pkg::KW_COUNT-1:0] r_kw_alive;
    logic [ard_pkg::POS_BITS-1:0] r_line_pos;

    // Next values.
    t_line_state                  n_line_state;
    logic [LB-1:0]                n_chunk_len;
    logic [LB-1:0]                n_chunk_cnt;
    t_frame_state                 n_frame_state;
    logic [LB-1:0]                n_pkt_len;
    logic [LB-1:0]                n_pkt_cnt;
    logic [ard_pkg::KW_COUNT-1:0] n_kw_alive;
    logic [ard_pkg::POS_BITS-1:0] n_line_pos;
    ard_pkg::t_event              n_out_event;
    logic [7:0]                   n_out_data;

    logic                         advance;
    logic                         in_take;
    logic [ard_pkg::KW_COUNT-1:0] kw_fed;
    ard_pkg::t_event              kw_event;

    // Handshakes: the parse step moves the input register into the output
    // register whenever the output register is free or being emptied.
    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_valid || advance);
    assign in_take = i_in.valid && i_in.ready;

    assign o_out.valid     = r_out_valid;
    assign o_out.event_res = r_out_event;
    assign o_out.data_byte = r_out_data;

    // Keyword matcher: which keywords survive this byte, and which one a
    // line feed at this position completes.
    always_comb begin
        logic found;
        found = 1'b0;
        kw_event = ard_pkg::EV_NONE;
        for (int k = 0; k < ard_pkg::KW_COUNT; k++) begin
            kw_fed[k] = r_kw_alive[k] && ard_pkg::kw_hit(3'(k), r_line_pos, r_in_byte);
            if (!found && kw_fed[k] &&
                ({1'b0, r_line_pos} + 6'd1 == {1'b0, ard_pkg::KW_LEN[k]})) begin
                found = 1'b1;
                kw_event = ard_pkg::KW_EVENT[k];
            end
        end
        if ((kw_event == ard_pkg::EV_CLOSED && r_sup_closed) ||
            (kw_event == ard_pkg::EV_WIFI_DROP && r_sup_wifi)) begin
            kw_event = ard_pkg::EV_NONE;
        end
    end

    // Parse step for the byte in the input register.
    always_comb begin
        t_line_state     st;
        ard_pkg::t_event fr_event;
        logic            hdr_done;
        logic [LB-1:0]   cnt_next;

        n_line_state  = r_line_state;
        n_chunk_len   = r_chunk_len;
        n_chunk_cnt   = r_chunk_cnt;
        n_frame_state = r_frame_state;
        n_pkt_len     = r_pkt_len;
        n_pkt_cnt     = r_pkt_cnt;
        n_kw_alive    = r_kw_alive;
        n_line_pos    = r_line_pos;
        n_out_event   = ard_pkg::EV_NONE;
        n_out_data    = 8'd0;
        st            = LS_NORMAL;
        fr_event      = ard_pkg::EV_NONE;
        hdr_done      = 1'b0;
        cnt_next      = r_pkt_cnt;

        case (r_line_state)
            // Chunk length digits up to the colon; other bytes are skipped.
            LS_CHUNK_LEN: begin
                if (ard_pkg::is_digit(r_in_byte)) begin
                    n_chunk_len = acc_dec(r_chunk_len, r_in_byte);
                end else if (r_in_byte == ard_pkg::CH_COLON) begin
                    n_chunk_cnt = '0;
                    if (r_chunk_len == '0) begin
                        n_line_state = LS_NORMAL;
                        n_out_event  = ard_pkg::EV_CHUNK_DONE;
                    end else begin
                        n_line_state = LS_CHUNK_DATA;
                    end
                end
            end

            // Chunk bytes go through the inner packet framer.
            LS_CHUNK_DATA: begin
                case (r_frame_state)
                    FS_EXPECT_S: begin
                        if (r_in_byte != ard_pkg::CH_S) begin
                            fr_event = ard_pkg::EV_FRAME_ERROR;
                        end else begin
                            n_frame_state = FS_LENGTH;
                            n_pkt_len     = '0;
                            n_pkt_cnt     = '0;
                        end
                    end
                    FS_LENGTH: begin
                        if (ard_pkg::is_digit(r_in_byte)) begin
                            n_pkt_len = acc_dec(r_pkt_len, r_in_byte);
                        end else if (r_in_byte == ard_pkg::CH_COLON) begin
                            n_frame_state = FS_DATA;
                        end else begin
                            n_frame_state = FS_EXPECT_S;
                            fr_event      = ard_pkg::EV_FRAME_ERROR;
                        end
                    end
                    default: begin
                        n_out_data = r_in_byte;
                        cnt_next   = sat_inc(r_pkt_cnt);
                        if (cnt_next >= r_pkt_len) begin
                            n_frame_state = FS_EXPECT_S;
                            n_pkt_len     = '0;
                            n_pkt_cnt     = '0;
                            fr_event      = ard_pkg::EV_PAYLOAD_LAST;
                        end else begin
                            n_pkt_cnt = cnt_next;
                            fr_event  = ard_pkg::EV_PAYLOAD;
                        end
                    end
                endcase
                n_out_event = fr_event;
                n_chunk_cnt = sat_inc(r_chunk_cnt);
                if (n_chunk_cnt >= r_chunk_len) begin
                    n_line_state = LS_NORMAL;
                    if (fr_event == ard_pkg::EV_NONE) begin
                        n_out_event = ard_pkg::EV_CHUNK_DONE;
                    end
                end
            end

            // Text lines: +IPD header detection and keyword matching.
            default: begin
                case (r_line_state)
                    LS_NEW_LINE: begin
                        st = (r_in_byte == ard_pkg::CH_PLUS) ? LS_PLUS : LS_NORMAL;
                    end
                    LS_PLUS: begin
                        st = (r_in_byte == ard_pkg::CH_I) ? LS_PLUS_I : LS_NORMAL;
                    end
                    LS_PLUS_I: begin
                        st = (r_in_byte == ard_pkg::CH_P) ? LS_PLUS_IP : LS_NORMAL;
                    end
                    LS_PLUS_IP: begin
                        st = (r_in_byte == ard_pkg::CH_D) ? LS_PLUS_IPD : LS_NORMAL;
                    end
                    LS_PLUS_IPD: begin
                        hdr_done = (r_in_byte == ard_pkg::CH_COMMA);
                        st       = LS_NORMAL;
                    end
                    LS_CR: begin
                        st = LS_CR;
                    end
                    default: begin
                        st = LS_NORMAL;
                    end
                endcase

                if (hdr_done) begin
                    n_line_state = LS_CHUNK_LEN;
                    n_chunk_len  = '0;
                    n_chunk_cnt  = '0;
                    n_kw_alive   = '1;
                    n_line_pos   = '0;
                end else if (st == LS_CR && r_in_byte == ard_pkg::CH_LF) begin
                    n_out_event  = kw_event;
                    n_line_state = LS_NEW_LINE;
                    n_kw_alive   = '1;
                    n_line_pos   = '0;
                end else begin
                    n_kw_alive = kw_fed;
                    n_line_pos = (r_line_pos != '1) ? r_line_pos + 5'd1 : r_line_pos;
                    if (st == LS_CR) begin
                        n_line_state = LS_NORMAL;
                    end else if (r_in_byte == ard_pkg::CH_CR) begin
                        n_line_state = LS_CR;
                    end else begin
                        n_line_state = st;
                    end
                end
            end
        endcase
    end

    // Input register, parser state, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_sup_closed  <= 1'b0;
            r_sup_wifi    <= 1'b0;
            r_line_state  <= LS_NEW_LINE;
            r_chunk_len   <= '0;
            r_chunk_cnt   <= '0;
            r_frame_state <= FS_EXPECT_S;
            r_pkt_len     <= '0;
            r_pkt_cnt     <= '0;
            r_kw_alive    <= '1;
            r_line_pos    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    ard_pkg::CFG_IDX_SUPPRESS_CLOSED:    r_sup_closed <= i_cfg_wdata[0];
                    ard_pkg::CFG_IDX_SUPPRESS_WIFI_DROP: r_sup_wifi   <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end

            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid   <= 1'b1;
                r_line_state  <= n_line_state;
                r_chunk_len   <= n_chunk_len;
                r_chunk_cnt   <= n_chunk_cnt;
                r_frame_state <= n_frame_state;
                r_pkt_len     <= n_pkt_len;
                r_pkt_cnt     <= n_pkt_cnt;
                r_kw_alive    <= n_kw_alive;
                r_line_pos    <= n_line_pos;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.rx_byte;
        end
        if (advance) begin
            r_out_event <= n_out_event;
            r_out_data  <= n_out_data;
        end
    end

endmodule

FILE: src/ard_checker.sv
// ----------------------------------------------------------------------------
// ard_checker: port level checks for the +IPD deframer
// Watches the channels of the top level and flags result items or handshake
// behavior that the deframer must never show.
// ----------------------------------------------------------------------------
module ard_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_out_event,
    input logic [7:0] i_out_data
);

    // A payload byte is only carried by the two payload events.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !(i_out_event == ard_pkg::EV_PAYLOAD ||
                         i_out_event == ard_pkg::EV_PAYLOAD_LAST)
        |-> i_out_data == 8'd0)
        else $error("data byte set on a non-payload item");

    // With the result register empty the input side always has room.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while no result is pending");

    // Reset empties the result register.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item present right after reset");

    // A stalled result item holds its contents.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready
        |=> i_out_valid && $stable(i_out_event) && $stable(i_out_data))
        else $error("stalled result item changed");

    // The input is refused only while a result item is pending.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid)
        else $error("input refused without a pending result");

endmodule

bind at_response_ipd_deframer_top ard_checker u_ard_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_event (o_out.event_res),
    .i_out_data  (o_out.data_byte)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the AT response +IPD deframer
// Feeds modem byte streams into the parser: status lines (exact and damaged),
// +IPD chunks carrying framed packets, broken headers, noise, and one chunk
// carrying a packet whose decimal lengths overflow the counters. A
// byte-level model of the parser predicts one event per accepted byte. The
// monitor compares every result item with the oldest prediction. Both sides
// idle at random, the receiver holds off once for a long stretch, and the
// suppress bits change between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     LEN_BITS     = ard_pkg::LENGTH_BITS_DEF;
    localparam longint LEN_MAX      = (longint'(1) << LEN_BITS) - 1;
    localparam int     PHASES       = 6;
    localparam int     PHASE_ITEMS  = 250;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     CYCLE_LIMIT  = 600000;
    // Suppress bit settings per phase, bit i belongs to phase i.
    localparam bit [PHASES-1:0] PLAN_CLOSED = 6'b101010;
    localparam bit [PHASES-1:0] PLAN_WIFI   = 6'b101100;
    // Saturation run: the chunk length 65539 and the packet length 65537 both
    // stick at the maximum. Counters that wrapped would end the chunk after
    // three bytes and the packet after one, so a few payload bytes show it.
    localparam int     SAT_BYTES    = 40;

    // Outer line states and inner framer states of the parser.
    typedef enum logic [3:0] {
        LN_NEW_LINE, LN_NORMAL, LN_PLUS, LN_PLUS_I, LN_PLUS_IP, LN_PLUS_IPD,
        LN_CR, LN_CHUNK_LEN, LN_CHUNK_DATA
    } t_line;

    typedef enum logic [1:0] {
        FR_WAIT_S, FR_LENGTH, FR_DATA
    } t_frame;

    typedef struct packed {
        ard_pkg::t_event ev;
        logic [7:0]      data;
    } t_result;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] gap;
    } t_tx_item;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [ard_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [ard_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

    ard_in_if  in_ch ();
    ard_out_if out_ch ();

    at_response_ipd_deframer_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #6 clk = ~clk;

    // Parser model state.
    t_line      line_st   = LN_NEW_LINE;
    t_frame     frame_st  = FR_WAIT_S;
    longint     chunk_len = 0;
    longint     chunk_cnt = 0;
    longint     pkt_len   = 0;
    longint     pkt_cnt   = 0;
    logic [6:0] kw_alive  = '1;
    logic [4:0] line_pos  = '0;
    logic       sup_closed = 1'b0;
    logic       sup_wifi   = 1'b0;

    // Predicted events, oldest first, and bytes waiting to be sent.
    t_result  event_q [$];
    t_tx_item tx_q [$];
    logic [7:0] frame_stream [$];

    int  pushed_cnt   = 0;
    int  accepted_cnt = 0;
    int  err_cnt      = 0;
    int  cycle_cnt    = 0;
    bit  tx_fast      = 1'b0;
    bit  tx_calm      = 1'b0;
    bit  line_open    = 1'b0;
    logic rx_fast     = 1'b0;
    logic rx_hold     = 1'b0;

    int       tx_wait;
    t_tx_item tx_cur;
    int       rx_wait;
    int       rx_stall;
    bit       rx_calm;
    t_result  want;

    // ------------------------------------------------------------------------
    // Model of the parser
    // ------------------------------------------------------------------------

    function automatic bit is_dec(input logic [7:0] b);
        return (b >= ard_pkg::CH_ZERO) && (b <= ard_pkg::CH_NINE);
    endfunction

    // Decimal accumulate that sticks at the counter maximum.
    function automatic longint add_digit(input longint v, input logic [7:0] b);
        longint r;
        r = v * 10 + (longint'(b) - longint'(ard_pkg::CH_ZERO));
        return (r > LEN_MAX) ? LEN_MAX : r;
    endfunction

    // Character pos of keyword k; the table stores keywords right aligned.
    function automatic logic [7:0] kw_char(input int k, input int pos);
        return ard_pkg::KW_TEXT[k][8 * (int'(ard_pkg::KW_LEN[k]) - 1 - pos) +: 8];
    endfunction

    // The event of the line that ends with the current LF.
    function automatic ard_pkg::t_event line_keyword_event();
        ard_pkg::t_event found;
        found = ard_pkg::EV_NONE;
        for (int k = 0; k < ard_pkg::KW_COUNT; k++) begin
            if (kw_alive[k] && int'(line_pos) + 1 == int'(ard_pkg::KW_LEN[k])) begin
                found = ard_pkg::KW_EVENT[k];
            end
        end
        if ((found == ard_pkg::EV_CLOSED && sup_closed) ||
            (found == ard_pkg::EV_WIFI_DROP && sup_wifi)) begin
            found = ard_pkg::EV_NONE;
        end
        return found;
    endfunction

    // Inner framer: 'S', decimal length, colon, then the payload.
    function automatic ard_pkg::t_event unframe_byte(input logic [7:0] b,
                                                     output logic [7:0] pay);
        ard_pkg::t_event ev;
        ev  = ard_pkg::EV_NONE;
        pay = 8'h00;
        case (frame_st)
            FR_WAIT_S: begin
                if (b != ard_pkg::CH_S) begin
                    ev = ard_pkg::EV_FRAME_ERROR;
                end else begin
                    frame_st = FR_LENGTH;
                    pkt_len  = 0;
                    pkt_cnt  = 0;
                end
            end
            FR_LENGTH: begin
                if (is_dec(b)) begin
                    pkt_len = add_digit(pkt_len, b);
                end else if (b == ard_pkg::CH_COLON) begin
                    frame_st = FR_DATA;
                end else begin
                    frame_st = FR_WAIT_S;
                    ev       = ard_pkg::EV_FRAME_ERROR;
                end
            end
            default: begin
                pay = b;
                if (pkt_cnt < LEN_MAX) pkt_cnt++;
                // A zero length packet still takes one byte.
                if (pkt_cnt >= pkt_len) begin
                    frame_st = FR_WAIT_S;
                    pkt_len  = 0;
                    pkt_cnt  = 0;
                    ev       = ard_pkg::EV_PAYLOAD_LAST;
                end else begin
                    ev = ard_pkg::EV_PAYLOAD;
                end
            end
        endcase
        return ev;
    endfunction

    // Predict the result item of one accepted byte.
    function automatic void parse_rx_byte(input logic [7:0] b);
        ard_pkg::t_event ev;
        logic [7:0]      pay;
        t_line           st;
        t_result         res;
        ev  = ard_pkg::EV_NONE;
        pay = 8'h00;
        st  = line_st;
        if (st == LN_CHUNK_LEN) begin
            // Non-digits other than the colon are skipped.
            if (is_dec(b)) begin
                chunk_len = add_digit(chunk_len, b);
            end else if (b == ard_pkg::CH_COLON) begin
                chunk_cnt = 0;
                if (chunk_len == 0) begin
                    line_st = LN_NORMAL;
                    ev      = ard_pkg::EV_CHUNK_DONE;
                end else begin
                    line_st = LN_CHUNK_DATA;
                end
            end
        end else if (st == LN_CHUNK_DATA) begin
            ev = unframe_byte(b, pay);
            if (chunk_cnt < LEN_MAX) chunk_cnt++;
            if (chunk_cnt >= chunk_len) begin
                line_st = LN_NORMAL;
                if (ev == ard_pkg::EV_NONE) ev = ard_pkg::EV_CHUNK_DONE;
            end
        end else if (st == LN_PLUS_IPD && b == ard_pkg::CH_COMMA) begin
            // Header complete: the header bytes belong to no line.
            line_st   = LN_CHUNK_LEN;
            chunk_len = 0;
            chunk_cnt = 0;
            kw_alive  = '1;
            line_pos  = '0;
        end else begin
            // Header tracking; a broken header falls back to a normal line.
            if (b == ard_pkg::CH_PLUS && st == LN_NEW_LINE) begin
                st = LN_PLUS;
            end else if (b == ard_pkg::CH_I && st == LN_PLUS) begin
                st = LN_PLUS_I;
            end else if (b == ard_pkg::CH_P && st == LN_PLUS_I) begin
                st = LN_PLUS_IP;
            end else if (b == ard_pkg::CH_D && st == LN_PLUS_IP) begin
                st = LN_PLUS_IPD;
            end else if (st >= LN_PLUS && st <= LN_PLUS_IPD) begin
                st = LN_NORMAL;
            end
            if (st == LN_NEW_LINE) st = LN_NORMAL;

            // Keyword matching sees every byte of the line.
            for (int k = 0; k < ard_pkg::KW_COUNT; k++) begin
                if (line_pos >= ard_pkg::KW_LEN[k] || kw_char(k, int'(line_pos)) != b) begin
                    kw_alive[k] = 1'b0;
                end
            end

            if (st == LN_CR) begin
                if (b == ard_pkg::CH_LF) begin
                    ev       = line_keyword_event();
                    st       = LN_NEW_LINE;
                    kw_alive = '1;
                    line_pos = '0;
                end else begin
                    st = LN_NORMAL;
                    if (line_pos < 5'd31) line_pos++;
                end
            end else begin
                if (b == ard_pkg::CH_CR) st = LN_CR;
                if (line_pos < 5'd31) line_pos++;
            end
            line_st = st;
        end
        res.ev   = ev;
        res.data = pay;
        event_q.push_back(res);
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    // Byte driver: waits the drawn gap before each item, then offers it.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                parse_rx_byte(in_ch.rx_byte);
                accepted_cnt++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (tx_q.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (tx_wait < int'(tx_q[0].gap)) begin
                    tx_wait++;
                    in_ch.valid <= 1'b0;
                end else begin
                    tx_cur = tx_q.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.rx_byte <= tx_cur.data;
                    tx_wait = 0;
                end
            end
        end
    end

    // Result monitor: checks each item and draws the stall before the next.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            rx_wait  = 0;
            rx_stall = 0;
            rx_calm  = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (event_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item, event %0d data %02h",
                                              out_ch.event_res, out_ch.data_byte));
                end else begin
                    want = event_q.pop_front();
                    if (out_ch.event_res !== want.ev) begin
                        report_mismatch($sformatf("event %0d, expected %0d",
                                                  out_ch.event_res, want.ev));
                    end
                    if (out_ch.data_byte !== want.data) begin
                        report_mismatch($sformatf("data %02h, expected %02h",
                                                  out_ch.data_byte, want.data));
                    end
                end
                if ($urandom_range(0, 99) < 3) rx_calm = !rx_calm;
                rx_stall = (rx_fast || rx_calm) ? 0 : $urandom_range(0, 14);
                rx_wait  = 0;
            end
            if (rx_hold) begin
                out_ch.ready <= 1'b0;
            end else if (rx_wait < rx_stall) begin
                rx_wait++;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[at_response_ipd_deframer_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b);
        t_tx_item item;
        if ($urandom_range(0, 99) < 3) tx_calm = !tx_calm;
        item.data = b;
        item.gap  = (tx_fast || tx_calm) ? 4'd0 : 4'($urandom_range(0, 14));
        tx_q.push_back(item);
        pushed_cnt++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_byte_avoiding(input logic [7:0] avoid,
                                                      input bit no_digits);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == avoid || (no_digits && is_dec(b)));
        return b;
    endfunction

    // Bytes that matter to the parser come up more often than pure chance.
    function automatic logic [7:0] noise_byte();
        string hot;
        hot = "+IPD,:SOKEFRNCL";
        case ($urandom_range(0, 5))
            0: return ard_pkg::CH_CR;
            1: return ard_pkg::CH_LF;
            2: return hot[$urandom_range(0, hot.len() - 1)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Bring the parser back to the start of a line whatever it saw last.
    task automatic start_line();
        if (line_open) push_text("\n\r\n");
        line_open = 1'b0;
    endtask

    // Append one framed packet, now and then damaged, to the inner stream.
    task automatic add_packet();
        int    r;
        int    plen;
        string num;
        r    = $urandom_range(0, 99);
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(0, 20);
        num  = $sformatf("%0d", plen);
        if (r < 8) begin
            repeat ($urandom_range(1, 3)) begin
                frame_stream.push_back(pick_byte_avoiding(ard_pkg::CH_S, 0));
            end
        end
        frame_stream.push_back(ard_pkg::CH_S);
        for (int i = 0; i < num.len(); i++) frame_stream.push_back(num[i]);
        if (r >= 8 && r < 14) begin
            // Bad length character; the framer goes back to waiting for S.
            frame_stream.push_back(pick_byte_avoiding(ard_pkg::CH_COLON, 1));
        end else begin
            frame_stream.push_back(ard_pkg::CH_COLON);
            repeat ((plen == 0) ? 1 : plen) frame_stream.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // One +IPD chunk of n bytes taken from the inner stream.
    task automatic push_chunk(input int n, input bit refill);
        string num;
        bit    junk;
        num  = $sformatf("%0d", n);
        junk = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 9) == 0) num = {"00", num};
        start_line();
        push_text("+IPD,");
        for (int i = 0; i < num.len(); i++) begin
            push_byte(num[i]);
            if (junk && $urandom_range(0, 2) == 0) begin
                push_byte(pick_byte_avoiding(ard_pkg::CH_COLON, 1));
            end
        end
        push_byte(ard_pkg::CH_COLON);
        repeat (n) begin
            if (refill && frame_stream.size() == 0) add_packet();
            push_byte(frame_stream.pop_front());
        end
    endtask

    // A status line, exact or damaged by one change.
    task automatic push_keyword_line();
        int         k;
        int         p;
        logic [7:0] line [$];
        k = $urandom_range(0, ard_pkg::KW_COUNT - 1);
        for (int i = 0; i < int'(ard_pkg::KW_LEN[k]); i++) line.push_back(kw_char(k, i));
        if ($urandom_range(0, 4) == 0) begin
            p = $urandom_range(0, line.size() - 1);
            case ($urandom_range(0, 2))
                0: line[p] = noise_byte();
                1: line.delete(p);
                default: line.insert(p, noise_byte());
            endcase
            line_open = 1'b1;
        end
        foreach (line[i]) push_byte(line[i]);
    endtask

    // Part of the +IPD header, then a byte that breaks it.
    task automatic push_broken_header();
        string hdr;
        int    n;
        hdr = "+IPD,";
        n   = $urandom_range(1, 4);
        start_line();
        for (int i = 0; i < n; i++) push_byte(hdr[i]);
        push_byte(pick_byte_avoiding(hdr[n], 0));
        repeat ($urandom_range(0, 4)) push_byte(noise_byte());
        push_text("\r\n");
        line_open = 1'b1;
    endtask

    task automatic push_noise();
        if ($urandom_range(0, 6) == 0) begin
            // A line longer than any keyword.
            repeat ($urandom_range(32, 40)) push_byte(8'($urandom_range(8'h41, 8'h5A)));
            push_text("\r\n");
        end else begin
            repeat ($urandom_range(1, 12)) push_byte(noise_byte());
        end
        line_open = 1'b1;
    endtask

    // Random mix of traffic until about n more bytes are queued.
    task automatic push_traffic(input int n);
        int target;
        int r;
        int size;
        target = pushed_cnt + n;
        while (pushed_cnt < target) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                push_keyword_line();
            end else if (r < 65) begin
                size = $urandom_range(0, 19);
                if (size == 0) size = 0;
                else if (size == 1) size = $urandom_range(25, 80);
                else size = $urandom_range(1, 24);
                push_chunk(size, 1'b1);
                if ($urandom_range(0, 4) == 0) line_open = 1'b1;
                else push_text("\r\n");
            end else if (r < 78) begin
                push_broken_header();
            end else begin
                push_noise();
            end
        end
    endtask

    task automatic write_cfg(input logic [ard_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == ard_pkg::CFG_IDX_SUPPRESS_CLOSED) sup_closed = val;
        else sup_wifi = val;
    endtask

    // Every queued byte accepted and every predicted item received.
    task automatic wait_drained();
        while (accepted_cnt != pushed_cnt || event_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            write_cfg(ard_pkg::CFG_IDX_SUPPRESS_CLOSED, PLAN_CLOSED[ph]);
            write_cfg(ard_pkg::CFG_IDX_SUPPRESS_WIFI_DROP, PLAN_WIFI[ph]);
            if (ph == 0) begin
                // Byte extremes, a CR followed by a second CR, an exact
                // status line, an empty chunk and a header broken after +IP.
                push_byte(8'h00);
                push_byte(8'hFF);
                push_text("\r\r\n\r\nOK\r\n+IPD,0:\r\n+IPX\r\n");
            end
            if (ph == 2) begin
                // Back-to-back bytes against a receiver that stops taking
                // results, so the parser fills and stalls its input.
                tx_fast = 1'b1;
                push_traffic(PHASE_ITEMS);
                tx_fast = 1'b0;
                @(posedge clk);
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end else begin
                push_traffic(PHASE_ITEMS);
            end
            wait_drained();
        end

        // Saturated lengths: finish the pending packets so the framer waits
        // for S, then a chunk and a packet whose lengths stick at the maximum.
        @(posedge clk);
        rx_fast <= 1'b1;
        tx_fast = 1'b1;
        line_open = 1'b1;
        if (frame_stream.size() > 0) push_chunk(frame_stream.size(), 1'b0);
        line_open = 1'b1;
        start_line();
        push_text("+IPD,65539:S65537:");
        repeat (SAT_BYTES) push_byte(8'($urandom_range(0, 255)));
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (event_q.size() != 0) report_mismatch("predicted items never arrived");
        if (err_cnt == 0) begin
            $display("[at_response_ipd_deframer_top] OK");
        end else begin
            $display("[at_response_ipd_deframer_top] ERROR");
        end
        $finish;
    end

endmodule
